### hw/rtl/p2c_pkg.sv
// Shared widths, angle constants, arctangent table and vector type for the polar converter.
package p2c_pkg;

   // Field widths of the pixel and of the complex sample.
   localparam int unsigned FIELD_W = 24;

   // Vector components carry 8 fraction bits and headroom for the rotation gain.
   localparam int unsigned XY_W = 34;

   // Residual angle in Q28 radians; after reduction it lies within plus or minus pi.
   localparam int unsigned Z_W = 32;

   // Wide angle used while the phase is reduced modulo two pi.
   localparam int unsigned ZW_W = 34;

   // Product of amplitude and gain constant.
   localparam int unsigned PROD_W = 55;

   // Number of entries in the arctangent table.
   localparam int unsigned ATAN_ENTRIES = 24;

   // Angle constants in Q28 radians.
   localparam logic signed [ZW_W-1:0] PI_WIDE      = 34'sd843314857;
   localparam logic signed [ZW_W-1:0] TWO_PI_WIDE  = 34'sd1686629713;
   localparam logic signed [Z_W-1:0]  PI_Q28       = 32'sd843314857;
   localparam logic signed [Z_W-1:0]  HALF_PI_Q28  = 32'sd421657428;

   // Gain constant pieces in Q30.
   localparam longint GAIN_BASE_Q30 = 64'sd652032874;
   localparam longint GAIN_TAIL_NUM = 64'sd434688583;

   // Rounded arctangent of two to the minus i, in Q28 radians.
   localparam logic signed [Z_W-1:0] ATAN_Q28 [ATAN_ENTRIES] = '{
      32'sd210828714, 32'sd124459457, 32'sd65760959, 32'sd33381290,
      32'sd16755422,  32'sd8387244,   32'sd4193963,  32'sd2097109,
      32'sd1048571,   32'sd524287,    32'sd262144,   32'sd131072,
      32'sd65536,     32'sd32768,     32'sd16384,    32'sd8192,
      32'sd4096,      32'sd2048,      32'sd1024,     32'sd512,
      32'sd256,       32'sd128,       32'sd64,       32'sd32
   };

   // One vector in flight through the rotation stages.
   typedef struct packed {
      logic signed [XY_W-1:0] x;
      logic signed [XY_W-1:0] y;
      logic signed [Z_W-1:0]  z;
   } vec_type;

endpackage

### hw/rtl/p2c_rotate.sv
// One registered micro-rotation stage of the polar-to-rectangular pipeline.
module p2c_rotate #(
   parameter int unsigned SHIFT = 0
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  logic             in_valid,
   input  p2c_pkg::vec_type in_vec,
   output logic             out_valid,
   output p2c_pkg::vec_type out_vec
);
   import p2c_pkg::*;

   logic    valid_ff;
   vec_type vec_ff;
   vec_type vec_in;
   logic signed [XY_W-1:0] dx;
   logic signed [XY_W-1:0] dy;

   // Rotate toward zero residual angle; the shifts round toward minus infinity.
   always_comb begin
      dx = in_vec.y >>> SHIFT;
      dy = in_vec.x >>> SHIFT;
      if (!in_vec.z[Z_W-1]) begin
         vec_in.x = in_vec.x - dx;
         vec_in.y = in_vec.y + dy;
         vec_in.z = in_vec.z - ATAN_Q28[SHIFT];
      end else begin
         vec_in.x = in_vec.x + dx;
         vec_in.y = in_vec.y - dy;
         vec_in.z = in_vec.z + ATAN_Q28[SHIFT];
      end
   end

   // Stage valid bit.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   // Stage payload.
   always_ff @(posedge clock) begin
      if (advance) begin
         vec_ff <= vec_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_vec   = vec_ff;

endmodule

### hw/rtl/polar_to_complex_pixel.sv
// Top level: pipelined polar-to-rectangular conversion of one pixel per item.
//
//   channel | direction | handshake              | payload
//   req     | in        | req_valid / req_stall  | req_amplitude, req_phase
//   rsp     | out       | rsp_valid / rsp_stall  | rsp_real_part, rsp_imag_part
//
// One item enters per cycle while the pipeline is not held; its path runs through phase
// reduction, quadrant fold, negate, the chain of rotation stages and the output register.
// Reset clears all valid bits; payload registers are not reset.
// The whole pipeline holds while a result waits under rsp_stall; req_stall follows.
module polar_to_complex_pixel #(
   parameter int unsigned ROTATION_STAGES = 20
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [p2c_pkg::FIELD_W-1:0]  req_amplitude,
   input  logic signed [p2c_pkg::FIELD_W-1:0]  req_phase,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [p2c_pkg::FIELD_W-1:0]  rsp_real_part,
   output logic signed [p2c_pkg::FIELD_W-1:0]  rsp_imag_part
);
   import p2c_pkg::*;

   // Inverse rotation gain in Q30 for this number of stages.
   localparam longint GAIN_LONG = GAIN_BASE_Q30 +
      ((GAIN_TAIL_NUM + (64'sd1 <<< (2 * ROTATION_STAGES - 1))) >>> (2 * ROTATION_STAGES));
   localparam logic signed [30:0] GAIN_Q30 = 31'(GAIN_LONG);
   localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(64'sd1 <<< 21);

   // Round off 8 fraction bits and clamp to the output range.
   function automatic logic signed [FIELD_W-1:0] round_sat(input logic signed [XY_W-1:0] v);
      logic signed [XY_W-1:0] sum;
      logic signed [XY_W-9:0] q;
      logic signed [XY_W-9:0] max_v;
      logic signed [XY_W-9:0] min_v;
      sum   = v + XY_W'(128);
      q     = sum[XY_W-1:8];
      max_v = (XY_W-8)'(24'sh7FFFFF);
      min_v = -max_v - (XY_W-8)'(1);
      if (q > max_v) begin
         return {1'b0, {(FIELD_W-1){1'b1}}};
      end else if (q < min_v) begin
         return {1'b1, {(FIELD_W-1){1'b0}}};
      end else begin
         return q[FIELD_W-1:0];
      end
   endfunction

   logic advance;

   logic                    s1_valid_ff;
   logic signed [Z_W-1:0]   s1_z_ff;
   logic signed [Z_W-1:0]   s1_z_in;
   logic signed [PROD_W-1:0] s1_prod_ff;
   logic signed [ZW_W-1:0]  z_wide;
   logic signed [ZW_W-1:0]  z_red;

   logic                    s2_valid_ff;
   logic signed [Z_W-1:0]   s2_z_ff;
   logic signed [Z_W-1:0]   s2_z_in;
   logic                    s2_flip_ff;
   logic                    s2_flip_in;
   logic signed [XY_W-1:0]  s2_x_ff;
   logic signed [PROD_W-1:0] prod_rnd;

   logic                    s3_valid_ff;
   vec_type                 s3_vec_ff;
   vec_type                 s3_vec_in;

   logic                    rot_valid [ROTATION_STAGES+1];
   vec_type                 rot_vec   [ROTATION_STAGES+1];

   logic                    rsp_valid_ff;
   logic signed [FIELD_W-1:0] rsp_real_part_ff;
   logic signed [FIELD_W-1:0] rsp_imag_part_ff;

   // The pipeline moves unless a finished item is held by the receiver.
   assign advance   = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !advance;

   // Stage 1: reduce the phase into [-pi, pi) and scale the amplitude by the gain.
   always_comb begin
      z_wide = {{2{req_phase[FIELD_W-1]}}, req_phase, 8'b0};
      if (z_wide >= PI_WIDE) begin
         z_red = z_wide - TWO_PI_WIDE;
      end else if (z_wide < -PI_WIDE) begin
         z_red = z_wide + TWO_PI_WIDE;
      end else begin
         z_red = z_wide;
      end
      s1_z_in = z_red[Z_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_z_ff    <= s1_z_in;
         s1_prod_ff <= PROD_W'(req_amplitude) * PROD_W'(GAIN_Q30);
      end
   end

   // Stage 2: fold the angle into [-pi/2, pi/2] and round the scaled amplitude.
   always_comb begin
      s2_flip_in = 1'b0;
      s2_z_in    = s1_z_ff;
      if (s1_z_ff > HALF_PI_Q28) begin
         s2_z_in    = s1_z_ff - PI_Q28;
         s2_flip_in = 1'b1;
      end else if (s1_z_ff < -HALF_PI_Q28) begin
         s2_z_in    = s1_z_ff + PI_Q28;
         s2_flip_in = 1'b1;
      end
      prod_rnd = s1_prod_ff + ROUND_HALF;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_z_ff    <= s2_z_in;
         s2_flip_ff <= s2_flip_in;
         s2_x_ff    <= XY_W'(prod_rnd >>> 22);
      end
   end

   // Stage 3: negate the vector for the folded half plane.
   always_comb begin
      s3_vec_in.x = s2_flip_ff ? -s2_x_ff : s2_x_ff;
      s3_vec_in.y = '0;
      s3_vec_in.z = s2_z_ff;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s3_vec_ff <= s3_vec_in;
      end
   end

   // Valid bits of the preparation stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   // Rotation stages, one shift amount each.
   assign rot_valid[0] = s3_valid_ff;
   assign rot_vec[0]   = s3_vec_ff;

   for (genvar i = 0; i < ROTATION_STAGES; i++) begin : g_rot
      p2c_rotate #(
         .SHIFT (i)
      ) u_rotate (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (rot_valid[i]),
         .in_vec    (rot_vec[i]),
         .out_valid (rot_valid[i+1]),
         .out_vec   (rot_vec[i+1])
      );
   end

   // Output register: rounding and saturation.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= rot_valid[ROTATION_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_real_part_ff <= round_sat(rot_vec[ROTATION_STAGES].x);
         rsp_imag_part_ff <= round_sat(rot_vec[ROTATION_STAGES].y);
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_real_part = rsp_real_part_ff;
   assign rsp_imag_part = rsp_imag_part_ff;

endmodule

### dv/polar_to_complex_pixel_tb.sv
// Self-checking testbench for the polar-to-rectangular pixel converter.
`timescale 1ns / 100ps

module polar_to_complex_pixel_tb;

   localparam int unsigned FW = p2c_pkg::FIELD_W;
   localparam int unsigned STAGES = 20;
   localparam int unsigned ATAN_COUNT = 24;
   localparam int unsigned RANDOM_PIXELS = 1228;

   // Angles in Q28 radians and the gain pieces in Q30.
   localparam longint PI_ANGLE = 64'sd843314857;
   localparam longint HALF_PI_ANGLE = 64'sd421657428;
   localparam longint TWO_PI_ANGLE = 64'sd1686629713;
   localparam longint GAIN_BASE = 64'sd652032874;
   localparam longint GAIN_TAIL = 64'sd434688583;
   localparam longint SAMPLE_MAX = 64'sd8388607;
   localparam longint SAMPLE_MIN = -64'sd8388608;

   // Phase landmarks in Q4.20 radians.
   localparam int PHASE_PI = 3294199;
   localparam int PHASE_HALF_PI = 1647099;
   localparam int PHASE_TWO_PI = 6588397;
   localparam int PHASE_3HALF_PI = 4941298;

   localparam longint ATAN_TABLE [ATAN_COUNT] = '{
      210828714, 124459457, 65760959, 33381290,
      16755422, 8387244, 4193963, 2097109,
      1048571, 524287, 262144, 131072,
      65536, 32768, 16384, 8192,
      4096, 2048, 1024, 512,
      256, 128, 64, 32
   };

   localparam bit TYPED = 1'b1;
   localparam bit PREDICT = 1'b0;

   typedef struct packed {
      logic signed [FW-1:0] re;
      logic signed [FW-1:0] im;
   } complex_sample_t;

   typedef struct packed {
      logic signed [FW-1:0] amp;
      logic signed [FW-1:0] phase;
      logic                 typed;
      logic signed [FW-1:0] re;
      logic signed [FW-1:0] im;
   } pixel_row_t;

   localparam int unsigned DIRECTED_COUNT = 23;

   // Directed pixels: zero amplitude is known exactly, the rest go to the predictor.
   localparam pixel_row_t DIRECTED [DIRECTED_COUNT] = '{
      '{24'sd0, 24'sd0, TYPED, 24'sd0, 24'sd0},
      '{24'sd0, 24'sd8388607, TYPED, 24'sd0, 24'sd0},
      '{24'sd0, -24'sd8388608, TYPED, 24'sd0, 24'sd0},
      '{24'sd8388607, 24'sd0, PREDICT, 24'sd0, 24'sd0},
      '{-24'sd8388608, 24'sd0, PREDICT, 24'sd0, 24'sd0},
      '{24'sd8388607, 24'(PHASE_HALF_PI), PREDICT, 24'sd0, 24'sd0},
      '{24'sd8388607, 24'(PHASE_HALF_PI + 1), PREDICT, 24'sd0, 24'sd0},
      '{-24'sd8388608, 24'(-PHASE_HALF_PI), PREDICT, 24'sd0, 24'sd0},
      '{-24'sd8388608, 24'(-PHASE_HALF_PI - 1), PREDICT, 24'sd0, 24'sd0},
      '{-24'sd8388608, 24'(PHASE_PI), PREDICT, 24'sd0, 24'sd0},
      '{24'sd8388607, 24'(PHASE_PI - 1), PREDICT, 24'sd0, 24'sd0},
      '{24'sd8388607, 24'(-PHASE_PI), PREDICT, 24'sd0, 24'sd0},
      '{-24'sd8388608, 24'(-PHASE_PI - 1), PREDICT, 24'sd0, 24'sd0},
      '{24'sd1, 24'sd1, PREDICT, 24'sd0, 24'sd0},
      '{-24'sd1, -24'sd1, PREDICT, 24'sd0, 24'sd0},
      '{24'sd8388607, 24'(PHASE_TWO_PI), PREDICT, 24'sd0, 24'sd0},
      '{-24'sd8388608, 24'(PHASE_TWO_PI + 1), PREDICT, 24'sd0, 24'sd0},
      '{24'sd8388607, 24'(-PHASE_TWO_PI), PREDICT, 24'sd0, 24'sd0},
      '{24'sd8388607, 24'sd8388607, PREDICT, 24'sd0, 24'sd0},
      '{-24'sd8388608, -24'sd8388608, PREDICT, 24'sd0, 24'sd0},
      '{24'sd8388607, 24'(PHASE_3HALF_PI), PREDICT, 24'sd0, 24'sd0},
      '{-24'sd8388608, 24'(-PHASE_3HALF_PI), PREDICT, 24'sd0, 24'sd0},
      '{24'sd2796202, -24'sd2796203, PREDICT, 24'sd0, 24'sd0}
   };

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic signed [FW-1:0] req_amplitude = '0;
   logic signed [FW-1:0] req_phase = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic signed [FW-1:0] rsp_real_part;
   logic signed [FW-1:0] rsp_imag_part;

   pixel_row_t      pixel_q [$];
   complex_sample_t sample_q [$];
   pixel_row_t      pixel_on_bus;
   pixel_row_t      row;
   complex_sample_t want;
   complex_sample_t oldest;
   int unsigned     gap_left = 0;
   int unsigned     calm_items = 0;
   int unsigned     stall_left = 0;
   int unsigned     open_left = 0;
   int unsigned     fail_count = 0;

   polar_to_complex_pixel #(
      .ROTATION_STAGES(STAGES)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_amplitude(req_amplitude),
      .req_phase(req_phase),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_real_part(rsp_real_part),
      .rsp_imag_part(rsp_imag_part)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Clamp a rounded component to the 24-bit sample range.
   function automatic logic signed [FW-1:0] clamp_sample(input longint v);
      if (v > SAMPLE_MAX) begin
         v = SAMPLE_MAX;
      end
      if (v < SAMPLE_MIN) begin
         v = SAMPLE_MIN;
      end
      return v[FW-1:0];
   endfunction

   // Expected complex sample: reduce and fold the phase, then rotate the scaled amplitude.
   function automatic complex_sample_t rotate_pixel(input logic signed [FW-1:0] amp_in,
                                                    input logic signed [FW-1:0] phase_in);
      longint          amp;
      longint          ang;
      longint          x;
      longint          y;
      longint          dx;
      longint          dy;
      longint          tail;
      longint          gain;
      bit              flip;
      complex_sample_t s;
      amp = amp_in;
      ang = phase_in;
      ang = ang * 256;
      flip = 1'b0;
      repeat (2) begin
         if (ang >= PI_ANGLE) begin
            ang = ang - TWO_PI_ANGLE;
         end
      end
      repeat (2) begin
         if (ang < -PI_ANGLE) begin
            ang = ang + TWO_PI_ANGLE;
         end
      end
      // Fold the outer half-planes into the right half-plane by negating the vector.
      if (ang > HALF_PI_ANGLE) begin
         ang = ang - PI_ANGLE;
         flip = 1'b1;
      end else if (ang < -HALF_PI_ANGLE) begin
         ang = ang + PI_ANGLE;
         flip = 1'b1;
      end
      tail = GAIN_TAIL + (64'sd1 <<< (2 * STAGES - 1));
      gain = GAIN_BASE + (tail >>> (2 * STAGES));
      x = (amp * gain + (64'sd1 <<< 21)) >>> 22;
      if (flip) begin
         x = -x;
      end
      y = 0;
      for (int i = 0; i < STAGES && i < ATAN_COUNT; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (ang >= 0) begin
            x = x - dx;
            y = y + dy;
            ang = ang - ATAN_TABLE[i];
         end else begin
            x = x + dx;
            y = y - dy;
            ang = ang + ATAN_TABLE[i];
         end
      end
      s.re = clamp_sample((x + 128) >>> 8);
      s.im = clamp_sample((y + 128) >>> 8);
      return s;
   endfunction

   // Idle length: mostly none or short, now and then long.
   function automatic int unsigned pick_idle();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 45) begin
         return 0;
      end else if (r < 85) begin
         return $urandom_range(1, 3);
      end else if (r < 97) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(13, 40);
   endfunction

   // Random pixel, weighted toward phase boundaries and extreme amplitudes.
   function automatic pixel_row_t random_pixel();
      pixel_row_t  p;
      int unsigned kind;
      int          k;
      kind = $urandom_range(0, 9);
      p = '0;
      p.typed = PREDICT;
      p.amp = 24'($urandom());
      p.phase = 24'($urandom());
      case (kind)
         5: begin
            p.amp = 24'($urandom_range(0, 255));
            if ($urandom_range(0, 1) == 1) begin
               p.amp = -p.amp;
            end
         end
         6: begin
            case ($urandom_range(0, 3))
               0: p.amp = 24'sd8388607;
               1: p.amp = -24'sd8388608;
               2: p.amp = 24'sd1;
               default: p.amp = -24'sd1;
            endcase
         end
         7: begin
            k = $urandom_range(0, 10);
            k = k - 5;
            p.phase = 24'((k * PHASE_PI) / 2 + int'($urandom_range(0, 8)) - 4);
         end
         8, 9: begin
            p.phase = 24'(int'($urandom_range(0, 2 * PHASE_PI)) - PHASE_PI);
         end
         default: begin
         end
      endcase
      return p;
   endfunction

   // Sender: record each accepted pixel, then present the next one after a random gap.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_valid && !req_stall) begin
            if (pixel_on_bus.typed) begin
               want.re = pixel_on_bus.re;
               want.im = pixel_on_bus.im;
            end else begin
               want = rotate_pixel(pixel_on_bus.amp, pixel_on_bus.phase);
            end
            sample_q.push_back(want);
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left = gap_left - 1;
               req_valid <= 1'b0;
            end else if (pixel_q.size() > 0) begin
               pixel_on_bus = pixel_q.pop_front();
               req_amplitude <= pixel_on_bus.amp;
               req_phase <= pixel_on_bus.phase;
               req_valid <= 1'b1;
               if (calm_items == 0 && $urandom_range(0, 49) == 0) begin
                  calm_items = $urandom_range(40, 120);
               end
               if (calm_items > 0) begin
                  calm_items = calm_items - 1;
                  gap_left = 0;
               end else begin
                  gap_left = pick_idle();
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: check each accepted sample against the oldest expectation, then stall at random.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (sample_q.size() == 0) begin
               fail_count = fail_count + 1;
               $display("%0t: unexpected sample real %0d imag %0d", $time,
                        rsp_real_part, rsp_imag_part);
            end else begin
               oldest = sample_q.pop_front();
               if (rsp_real_part !== oldest.re || rsp_imag_part !== oldest.im) begin
                  fail_count = fail_count + 1;
                  $display("%0t: real expected %0d got %0d, imag expected %0d got %0d",
                           $time, oldest.re, rsp_real_part, oldest.im, rsp_imag_part);
               end
            end
         end
         if (stall_left == 0 && open_left == 0) begin
            stall_left = pick_idle();
            if ($urandom_range(0, 19) == 0) begin
               open_left = $urandom_range(100, 300);
            end else begin
               open_left = $urandom_range(0, 12);
            end
         end
         if (stall_left > 0) begin
            stall_left = stall_left - 1;
            rsp_stall <= 1'b1;
         end else begin
            if (open_left > 0) begin
               open_left = open_left - 1;
            end
            rsp_stall <= 1'b0;
         end
      end
   end

   // Stimulus, reset and end of run.
   initial begin
      for (int n = 0; n < DIRECTED_COUNT; n++) begin
         pixel_q.push_back(DIRECTED[n]);
      end
      for (int n = 0; n < RANDOM_PIXELS; n++) begin
         row = random_pixel();
         pixel_q.push_back(row);
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      while (pixel_q.size() != 0 || req_valid) begin
         @(posedge clock);
      end
      while (sample_q.size() != 0) begin
         @(posedge clock);
      end
      // Give a stray extra sample time to come out of the pipeline.
      repeat (STAGES + 10) @(posedge clock);
      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // Hard limit on the run time.
   initial begin
      #15_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
